>>> rtl/dmsc_pkg.sv
// Shared types, constants and the rate table of the delta-modulation sample channel.
package dmsc_pkg;

    typedef enum logic [1:0] {
        CMD_REG_WRITE = 2'd0,
        CMD_ENABLE    = 2'd1,
        CMD_TICK      = 2'd2,
        CMD_DMA_BYTE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_CTRL   = 2'd0,
        REG_LEVEL  = 2'd1,
        REG_START  = 2'd2,
        REG_LENGTH = 2'd3
    } reg_index_t;

    localparam logic [8:0]  RESET_PERIOD = 9'd428;
    localparam logic [15:0] START_BASE   = 16'hC000;
    localparam logic [15:0] WRAP_BASE    = 16'h8000;
    localparam logic [6:0]  LEVEL_TOP    = 7'd125;
    localparam logic [6:0]  LEVEL_FLOOR  = 7'd2;
    localparam logic [2:0]  LAST_BIT     = 3'd7;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] reg_index;
        logic [7:0] data_byte;
        logic       enable_on;
        logic [4:0] elapsed_cycles;
    } dmsc_item_t;

    typedef struct packed {
        logic [6:0]        level;
        logic signed [9:0] countdown;
        logic [8:0]        period;
        logic [2:0]        bit_position;
        logic [7:0]        shift_byte;
        logic              shift_valid;
        logic [7:0]        hold_byte;
        logic              hold_valid;
        logic [11:0]       bytes_left;
        logic [11:0]       length_setting;
        logic [15:0]       start_address;
        logic [15:0]       fetch_pointer;
        logic              loop_mode;
        logic              irq_enable;
        logic              irq_flag;
        logic              fetch_outstanding;
    } dmsc_state_t;

    typedef struct packed {
        logic [6:0]  level_out;
        logic        fetch_request;
        logic [15:0] fetch_address;
        logic        irq_pending;
        logic        active;
    } dmsc_result_t;

    localparam dmsc_state_t STATE_RESET = '{
        level:             7'd0,
        countdown:         10'sd428,
        period:            RESET_PERIOD,
        bit_position:      3'd0,
        shift_byte:        8'd0,
        shift_valid:       1'b0,
        hold_byte:         8'd0,
        hold_valid:        1'b0,
        bytes_left:        12'd0,
        length_setting:    12'd1,
        start_address:     START_BASE,
        fetch_pointer:     START_BASE,
        loop_mode:         1'b0,
        irq_enable:        1'b0,
        irq_flag:          1'b0,
        fetch_outstanding: 1'b0
    };

    function automatic logic [8:0] rate_period(input logic [3:0] idx);
        logic [8:0] p;
        unique case (idx)
            4'd0:  p = 9'd428;
            4'd1:  p = 9'd380;
            4'd2:  p = 9'd340;
            4'd3:  p = 9'd320;
            4'd4:  p = 9'd286;
            4'd5:  p = 9'd254;
            4'd6:  p = 9'd226;
            4'd7:  p = 9'd214;
            4'd8:  p = 9'd190;
            4'd9:  p = 9'd160;
            4'd10: p = 9'd142;
            4'd11: p = 9'd128;
            4'd12: p = 9'd106;
            4'd13: p = 9'd84;
            4'd14: p = 9'd72;
            default: p = 9'd54;
        endcase
        return p;
    endfunction

endpackage

>>> rtl/delta_mod_sample_channel_top.sv
// Top level of the delta-modulation sample channel: input register, state and result register.
// Accepted transactions wait in the input register; their results go to the result register.
// One transaction per cycle unless stalled; single-pass step logic updates all state at once.
// A result waiting on out_ready holds the step, and the input register still takes one more.
// Reset (rst_n low, asynchronous) restores the channel state and empties both registers.
module delta_mod_sample_channel_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [1:0]  reg_index,
    input  logic [7:0]  data_byte,
    input  logic        enable_on,
    input  logic [4:0]  elapsed_cycles,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [6:0]  level_out,
    output logic        fetch_request,
    output logic [15:0] fetch_address,
    output logic        irq_pending,
    output logic        active
);
    import dmsc_pkg::*;

    dmsc_item_t   item_reg;
    logic         item_valid_reg;
    dmsc_state_t  state_reg;
    dmsc_state_t  state_next;
    dmsc_result_t result_reg;
    dmsc_result_t result_next;
    logic         out_valid_reg;
    logic         advance;

    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;

    dmsc_step u_step (
        .cur  (state_reg),
        .item (item_reg),
        .nxt  (state_next),
        .res  (result_next)
    );

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= '{cmd: cmd, reg_index: reg_index, data_byte: data_byte,
                          enable_on: enable_on, elapsed_cycles: elapsed_cycles};
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= STATE_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                item_valid_reg <= in_valid;
            end
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign level_out     = result_reg.level_out;
    assign fetch_request = result_reg.fetch_request;
    assign fetch_address = result_reg.fetch_address;
    assign irq_pending   = result_reg.irq_pending;
    assign active        = result_reg.active;

    // Every fetch address lies in the upper half of the address space.
    a_fetch_addr_high: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fetch_request) |-> fetch_address[15])
        else $error("fetch address below the sample region");

    // No address is reported without a fetch.
    a_fetch_addr_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !fetch_request) |-> (fetch_address == 16'd0))
        else $error("fetch address driven without a fetch");

    // The timer is always reloaded to a positive count.
    a_countdown_pos: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.countdown > 10'sd0)
        else $error("timer count not positive after a step");

    // A fetch can only be pending while sample bytes remain.
    a_outstanding_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.fetch_outstanding |-> (state_reg.bytes_left != 12'd0))
        else $error("fetch pending with no bytes left");

endmodule

>>> rtl/dmsc_step.sv
// Next-state and result logic of the channel for one transaction.
module dmsc_step (
    input  dmsc_pkg::dmsc_state_t  cur,
    input  dmsc_pkg::dmsc_item_t   item,
    output dmsc_pkg::dmsc_state_t  nxt,
    output dmsc_pkg::dmsc_result_t res
);
    import dmsc_pkg::*;

    logic signed [9:0] cd_sub;
    logic              req;
    logic [15:0]       req_addr;
    logic [11:0]       left_dec;

    assign cd_sub   = cur.countdown - $signed({5'd0, item.elapsed_cycles});
    assign left_dec = cur.bytes_left - 12'd1;

    always_comb
    begin
        nxt      = cur;
        req      = 1'b0;
        req_addr = 16'd0;
        unique case (cmd_t'(item.cmd))
            CMD_REG_WRITE:
            begin
                unique case (reg_index_t'(item.reg_index))
                    REG_CTRL:
                    begin
                        nxt.irq_enable = item.data_byte[7];
                        nxt.loop_mode  = item.data_byte[6];
                        nxt.period     = rate_period(item.data_byte[3:0]);
                        if (!item.data_byte[7])
                        begin
                            nxt.irq_flag = 1'b0;
                        end
                    end
                    REG_LEVEL:  nxt.level = item.data_byte[6:0];
                    REG_START:  nxt.start_address = START_BASE | {2'b00, item.data_byte, 6'd0};
                    REG_LENGTH: nxt.length_setting = {item.data_byte, 4'h1};
                    default:    nxt.level = cur.level;
                endcase
            end
            CMD_ENABLE:
            begin
                if (item.enable_on)
                begin
                    if (cur.bytes_left == 12'd0)
                    begin
                        nxt.fetch_pointer = cur.start_address;
                        nxt.bytes_left    = cur.length_setting;
                        if (!cur.hold_valid && cur.length_setting != 12'd0
                            && !cur.fetch_outstanding)
                        begin
                            nxt.fetch_outstanding = 1'b1;
                            req                   = 1'b1;
                            req_addr              = cur.start_address;
                        end
                    end
                end
                else
                begin
                    nxt.fetch_outstanding = 1'b0;
                    nxt.bytes_left        = 12'd0;
                end
                nxt.irq_flag = 1'b0;
            end
            CMD_TICK:
            begin
                // The tick is always shorter than the fastest period, so the timer
                // expires at most once per transaction.
                if (cd_sub <= 10'sd0)
                begin
                    nxt.countdown = cd_sub + $signed({1'b0, cur.period});
                    if (cur.shift_valid)
                    begin
                        if (cur.shift_byte[cur.bit_position])
                        begin
                            if (cur.level <= LEVEL_TOP)
                            begin
                                nxt.level = cur.level + 7'd2;
                            end
                        end
                        else if (cur.level >= LEVEL_FLOOR)
                        begin
                            nxt.level = cur.level - 7'd2;
                        end
                    end
                    if (cur.bit_position == LAST_BIT)
                    begin
                        nxt.bit_position = 3'd0;
                        nxt.shift_byte   = cur.hold_byte;
                        nxt.shift_valid  = cur.hold_valid;
                        nxt.hold_valid   = 1'b0;
                    end
                    else
                    begin
                        nxt.bit_position = cur.bit_position + 3'd1;
                    end
                    if (!nxt.hold_valid && cur.bytes_left != 12'd0 && !cur.fetch_outstanding)
                    begin
                        nxt.fetch_outstanding = 1'b1;
                        req                   = 1'b1;
                        req_addr              = cur.fetch_pointer;
                    end
                end
                else
                begin
                    nxt.countdown = cd_sub;
                end
            end
            default:
            begin
                if (cur.bytes_left != 12'd0)
                begin
                    nxt.hold_byte         = item.data_byte;
                    nxt.hold_valid        = 1'b1;
                    nxt.fetch_outstanding = 1'b0;
                    nxt.fetch_pointer     = (cur.fetch_pointer + 16'd1) | WRAP_BASE;
                    nxt.bytes_left        = left_dec;
                    if (left_dec == 12'd0)
                    begin
                        if (cur.loop_mode)
                        begin
                            nxt.bytes_left    = cur.length_setting;
                            nxt.fetch_pointer = cur.start_address;
                        end
                        else if (cur.irq_enable)
                        begin
                            nxt.irq_flag = 1'b1;
                        end
                    end
                end
            end
        endcase
    end

    assign res.level_out     = nxt.level;
    assign res.fetch_request = req;
    assign res.fetch_address = req_addr;
    assign res.irq_pending   = nxt.irq_flag;
    assign res.active        = (nxt.bytes_left != 12'd0);

endmodule
